// ----- rtl/bb3_pkg.sv -----
`timescale 1ns / 1ps
package bb3_pkg;

   // configuration register geometry
   localparam int CFG_W_BITS = 11;
   localparam int CFG_H_BITS = 13;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
   localparam logic [CFG_W_BITS-1:0] RST_IMAGE_WIDTH  = 11'd640;
   localparam logic [CFG_H_BITS-1:0] RST_IMAGE_HEIGHT = 13'd480;

   // default sizing
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;

   // datapath widths
   localparam int PIX_W     = 8;
   localparam int RGB_W     = 3 * PIX_W;
   localparam int SUM_W     = 12;  // nine pixels of 255
   localparam int CNT_W     = 4;   // up to nine neighbors
   localparam int NUM_W     = 13;  // 2*sum + count
   localparam int DEN_W     = 5;   // 2*count
   localparam int DIV_STEPS = 8;   // one quotient bit per cell

   // request travelling down the divider chain
   typedef struct packed {
      logic                        valid;
      logic [2:0][NUM_W-1:0]       rem;
      logic [2:0][PIX_W-1:0]       quot;
      logic [DEN_W-1:0]            dvsr;
      logic                        last;
      logic                        eoi;
   } div_type;

endpackage

// ----- rtl/bb3_ram.sv -----
`timescale 1ns / 1ps
module bb3_ram #(
   parameter int DATA_W = 24,
   parameter int DEPTH  = 3072
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/bb3_div_cell.sv -----
`timescale 1ns / 1ps
module bb3_div_cell #(
   parameter int BIT = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  bb3_pkg::div_type    d_in,
   output bb3_pkg::div_type    d_out
);
   import bb3_pkg::*;

   div_type          d_in_stage;
   div_type          d_ff;
   logic [NUM_W-1:0] trial;

   // restoring step: try the shifted divisor against each channel remainder
   always_comb begin
      d_in_stage = d_in;
      trial      = NUM_W'(d_in.dvsr) << BIT;
      for (int ch = 0; ch < 3; ch++) begin
         if (d_in.rem[ch] >= trial) begin
            d_in_stage.rem[ch]       = d_in.rem[ch] - trial;
            d_in_stage.quot[ch][BIT] = 1'b1;
         end
      end
   end

   // hand to the neighbor
   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff.valid <= 1'b0;
      end else begin
         d_ff.valid <= d_in_stage.valid;
      end
      d_ff.rem  <= d_in_stage.rem;
      d_ff.quot <= d_in_stage.quot;
      d_ff.dvsr <= d_in_stage.dvsr;
      d_ff.last <= d_in_stage.last;
      d_ff.eoi  <= d_in_stage.eoi;
   end

   assign d_out = d_ff;

endmodule

// ----- rtl/box_blur_3x3_edge_clamped_unit.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake          Payload
// req       in   req_valid/ready    req_func, req_in_red/green/blue
// rsp       out  rsp_valid/ready    rsp_out_red/green/blue, rsp_last_of_run, rsp_end_of_image
// csr       in   csr_we             csr_index, csr_wdata
//
// A request that makes no result is taken without leaving the idle state. Each result passes
// through the window sequencer (setup, nine line store reads on one read port, accumulate,
// feed) and then the divider chain, one quotient bit per cell, before it shows on rsp.
// A second result of the same request is read while the first is in the chain and feeds
// only once the chain and the output register are empty, and until it feeds, the request
// holds off the next one.
// Reset is synchronous; the line store is not cleared. A stalled rsp holds the output
// register while the next request is taken; the sequencer waits before feeding the chain.
module box_blur_3x3_edge_clamped_unit #(
   parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_func,
   input  logic [bb3_pkg::PIX_W-1:0]      req_in_red,
   input  logic [bb3_pkg::PIX_W-1:0]      req_in_green,
   input  logic [bb3_pkg::PIX_W-1:0]      req_in_blue,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bb3_pkg::PIX_W-1:0]      rsp_out_red,
   output logic [bb3_pkg::PIX_W-1:0]      rsp_out_green,
   output logic [bb3_pkg::PIX_W-1:0]      rsp_out_blue,
   output logic                           rsp_last_of_run,
   output logic                           rsp_end_of_image,
   input  logic                           csr_we,
   input  logic [bb3_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bb3_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bb3_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH = 3 * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_LAST  = 3'd3;
   localparam logic [2:0] S_FEED  = 3'd4;

   logic [CFG_W_BITS-1:0] width_ff;
   logic [CFG_H_BITS-1:0] height_ff;
   logic [CW-1:0]         eff_w;
   logic [RW-1:0]         eff_h;
   logic [31:0]           w32, h32;

   logic [2:0]  state_ff, state_in;
   logic [RW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in, win_row_ff, win_row_in;
   logic [CW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in, win_col_ff, win_col_in;
   logic [1:0]  in_slot_ff, in_slot_in, out_slot_ff, out_slot_in, win_slot_ff, win_slot_in;
   logic        in_done_ff, in_done_in;
   logic [1:0]  pend_ff, pend_in;
   logic        win_last_ff, win_last_in, win_eoi_ff, win_eoi_in;
   logic [1:0]  step_r_ff, step_r_in, step_c_ff, step_c_in;
   logic        rd_tag_ff, rd_tag_in;
   logic [2:0][SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   logic        req_acc;
   logic        wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [RGB_W-1:0] rd_data;
   logic        row_ok, col_ok;
   logic [1:0]  rd_slot;
   logic [CW:0] rd_col;
   logic        e1, e2;

   div_type feed;
   div_type chain [DIV_STEPS];
   logic    chain_busy;

   logic                  rsp_valid_ff;
   logic [2:0][PIX_W-1:0] rsp_pix_ff;
   logic                  rsp_last_ff, rsp_eoi_ff;

   // clamp the registers to the usable range
   always_comb begin
      w32 = 32'(width_ff);
      h32 = 32'(height_ff);
      if (w32 == 32'd0) w32 = 32'd1;
      else if (w32 > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
      if (h32 == 32'd0) h32 = 32'd1;
      else if (h32 > 32'(MAX_HEIGHT)) h32 = 32'(MAX_HEIGHT);
      eff_w = w32[CW-1:0];
      eff_h = h32[RW-1:0];
   end

   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign wr_en     = req_acc && !req_func && !in_done_ff;
   assign wr_addr   = AW'(32'(in_slot_ff) * 32'(MAX_WIDTH) + 32'(in_col_ff));
   assign e1        = (in_row_ff != '0) && (in_col_ff != '0);
   assign e2        = (in_row_ff != '0) && (in_col_ff == eff_w - CW'(1));

   // window tap position and whether it lies inside the image
   always_comb begin
      row_ok = 1'b1;
      col_ok = 1'b1;
      rd_slot = win_slot_ff;
      case (step_r_ff)
         2'd0: begin
            row_ok  = (win_row_ff != '0);
            rd_slot = (win_slot_ff == 2'd0) ? 2'd2 : win_slot_ff - 2'd1;
         end
         2'd2: begin
            row_ok  = ((RW+1)'(win_row_ff) + (RW+1)'(1)) < (RW+1)'(eff_h);
            rd_slot = (win_slot_ff == 2'd2) ? 2'd0 : win_slot_ff + 2'd1;
         end
         default: ;
      endcase
      case (step_c_ff)
         2'd0: col_ok = (win_col_ff != '0);
         2'd2: col_ok = ((CW+1)'(win_col_ff) + (CW+1)'(1)) < (CW+1)'(eff_w);
         default: ;
      endcase
      rd_col = (CW+1)'(win_col_ff) + (CW+1)'(step_c_ff) - (CW+1)'(1);
      if (!col_ok) rd_col = (CW+1)'(win_col_ff);
   end

   assign rd_addr = AW'(32'(rd_slot) * 32'(MAX_WIDTH) + 32'(rd_col));

   bb3_ram #(.DATA_W(RGB_W), .DEPTH(DEPTH)) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_in_red, req_in_green, req_in_blue}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      in_slot_in  = in_slot_ff;
      in_done_in  = in_done_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;
      out_slot_in = out_slot_ff;
      pend_in     = pend_ff;
      win_row_in  = win_row_ff;
      win_col_in  = win_col_ff;
      win_slot_in = win_slot_ff;
      win_last_in = win_last_ff;
      win_eoi_in  = win_eoi_ff;
      step_r_in   = step_r_ff;
      step_c_in   = step_c_ff;
      rd_tag_in   = 1'b0;
      sum_in      = sum_ff;
      cnt_in      = cnt_ff;
      feed        = '0;

      // fold in the tap read last cycle
      if (rd_tag_ff) begin
         sum_in[0] = sum_ff[0] + SUM_W'(rd_data[2*PIX_W +: PIX_W]);
         sum_in[1] = sum_ff[1] + SUM_W'(rd_data[PIX_W +: PIX_W]);
         sum_in[2] = sum_ff[2] + SUM_W'(rd_data[0 +: PIX_W]);
         cnt_in    = cnt_ff + CNT_W'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_func) begin
                  if (in_done_ff) begin
                     pend_in  = 2'd1;
                     state_in = S_SETUP;
                  end
               end else if (!in_done_ff) begin
                  pend_in = 2'(e1) + 2'(e2);
                  if (e1 || e2) state_in = S_SETUP;
                  if ((CW+1)'(in_col_ff) + (CW+1)'(1) >= (CW+1)'(eff_w)) begin
                     in_col_in  = '0;
                     in_row_in  = in_row_ff + RW'(1);
                     in_slot_in = (in_slot_ff == 2'd2) ? 2'd0 : in_slot_ff + 2'd1;
                     if ((RW+1)'(in_row_ff) + (RW+1)'(1) >= (RW+1)'(eff_h)) begin
                        in_done_in = 1'b1;
                     end
                  end else begin
                     in_col_in = in_col_ff + CW'(1);
                  end
               end
            end
         end
         S_SETUP: begin
            win_row_in  = out_row_ff;
            win_col_in  = out_col_ff;
            win_slot_in = out_slot_ff;
            win_last_in = (pend_ff == 2'd1);
            win_eoi_in  = (out_row_ff == eff_h - RW'(1)) && (out_col_ff == eff_w - CW'(1));
            pend_in     = pend_ff - 2'd1;
            step_r_in   = 2'd0;
            step_c_in   = 2'd0;
            sum_in      = '0;
            cnt_in      = '0;
            if ((CW+1)'(out_col_ff) + (CW+1)'(1) >= (CW+1)'(eff_w)) begin
               out_col_in  = '0;
               out_row_in  = out_row_ff + RW'(1);
               out_slot_in = (out_slot_ff == 2'd2) ? 2'd0 : out_slot_ff + 2'd1;
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
            // image fully drained: start over
            if (win_eoi_in) begin
               in_row_in   = '0;
               in_col_in   = '0;
               in_slot_in  = '0;
               in_done_in  = 1'b0;
               out_row_in  = '0;
               out_col_in  = '0;
               out_slot_in = '0;
            end
            state_in = S_READ;
         end
         S_READ: begin
            rd_tag_in = row_ok && col_ok;
            if (step_c_ff == 2'd2) begin
               step_c_in = 2'd0;
               step_r_in = step_r_ff + 2'd1;
               if (step_r_ff == 2'd2) state_in = S_LAST;
            end else begin
               step_c_in = step_c_ff + 2'd1;
            end
         end
         S_LAST: begin
            state_in = S_FEED;
         end
         S_FEED: begin
            if (!rsp_valid_ff && !chain_busy) begin
               feed.valid = 1'b1;
               for (int ch = 0; ch < 3; ch++) begin
                  feed.rem[ch] = NUM_W'({sum_ff[ch], 1'b0}) + NUM_W'(cnt_ff);
               end
               feed.dvsr = DEN_W'({cnt_ff, 1'b0});
               feed.last = win_last_ff;
               feed.eoi  = win_eoi_ff;
               state_in  = (pend_ff != 2'd0) ? S_SETUP : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // register write restarts the image
      if (csr_we) begin
         in_row_in   = '0;
         in_col_in   = '0;
         in_slot_in  = '0;
         in_done_in  = 1'b0;
         out_row_in  = '0;
         out_col_in  = '0;
         out_slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         width_ff    <= RST_IMAGE_WIDTH;
         height_ff   <= RST_IMAGE_HEIGHT;
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         in_slot_ff  <= '0;
         in_done_ff  <= 1'b0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         out_slot_ff <= '0;
         pend_ff     <= '0;
         rd_tag_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         in_row_ff   <= in_row_in;
         in_col_ff   <= in_col_in;
         in_slot_ff  <= in_slot_in;
         in_done_ff  <= in_done_in;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
         out_slot_ff <= out_slot_in;
         pend_ff     <= pend_in;
         rd_tag_ff   <= rd_tag_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_IMAGE_WIDTH:  width_ff  <= csr_wdata[CFG_W_BITS-1:0];
               REG_IMAGE_HEIGHT: height_ff <= csr_wdata[CFG_H_BITS-1:0];
               default: ;
            endcase
         end
      end
      win_row_ff  <= win_row_in;
      win_col_ff  <= win_col_in;
      win_slot_ff <= win_slot_in;
      win_last_ff <= win_last_in;
      win_eoi_ff  <= win_eoi_in;
      step_r_ff   <= step_r_in;
      step_c_ff   <= step_c_in;
      sum_ff      <= sum_in;
      cnt_ff      <= cnt_in;
   end

   // divider chain, one quotient bit per cell, most significant first
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      if (k == 0) begin : g_head
         bb3_div_cell #(.BIT(DIV_STEPS - 1 - k)) u_cell (
            .clock (clock), .reset (reset), .d_in (feed), .d_out (chain[k])
         );
      end else begin : g_body
         bb3_div_cell #(.BIT(DIV_STEPS - 1 - k)) u_cell (
            .clock (clock), .reset (reset), .d_in (chain[k-1]), .d_out (chain[k])
         );
      end
   end

   always_comb begin
      chain_busy = 1'b0;
      for (int k = 0; k < DIV_STEPS; k++) begin
         chain_busy = chain_busy | chain[k].valid;
      end
   end

   // output register: load from the chain tail, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (chain[DIV_STEPS-1].valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (chain[DIV_STEPS-1].valid) begin
         rsp_pix_ff  <= chain[DIV_STEPS-1].quot;
         rsp_last_ff <= chain[DIV_STEPS-1].last;
         rsp_eoi_ff  <= chain[DIV_STEPS-1].eoi;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_red      = rsp_pix_ff[0];
   assign rsp_out_green    = rsp_pix_ff[1];
   assign rsp_out_blue     = rsp_pix_ff[2];
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_end_of_image = rsp_eoi_ff;

endmodule
